// File: sv/fan_speed_controller_macros.svh
// ----------------------------------------------------------------------------
// Fan speed controller assertion macros
// Shared concurrent assertion forms for the fan speed controller checkers.
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_CONTROLLER_MACROS_SVH
`define FAN_SPEED_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fan speed controller check failed");

// Next-cycle implication, disabled during reset.
`define FSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fan speed controller check failed");

`endif

// File: sv/fsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller package
// Widths, constants, register indexes and shared types.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int TEMP_W     = 13;
    localparam int PCT_W      = 7;
    localparam int LEVEL_W    = 15;
    localparam int TIME_W     = 32;
    localparam int DT_W       = 13;
    localparam int RAMP_W     = 8;
    localparam int BOOST_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam int DIV_NUM_W  = 29;
    localparam int DIV_DEN_W  = 13;

    localparam logic [DT_W-1:0]    DEFAULT_STEP_MS = DT_W'(500);
    localparam logic [DT_W-1:0]    DT_MAX          = DT_W'(5000);
    localparam logic [LEVEL_W-1:0] FULL_LEVEL      = LEVEL_W'(25600);
    localparam logic [PCT_W-1:0]   PCT_MAX         = PCT_W'(100);

    // ramp step = round(rate * 256 * dt / 1000) = floor((32 * rate * dt + 62) / 125),
    // the division done as * ceil(2^32 / 125) >> 32
    localparam int STEP_Z_W   = 26;
    localparam int STEP_P_W   = 52;
    localparam int STEP_SHIFT = 32;
    localparam logic [STEP_Z_W-1:0] STEP_BIAS  = STEP_Z_W'(62);
    localparam logic [STEP_Z_W-1:0] STEP_RECIP = STEP_Z_W'(34359739);

    // duty = (level * 255 + 12800) / 25600, done as >> 8 then * ceil(2^22 / 100) >> 22
    localparam int DUTY_X_W   = 23;
    localparam int DUTY_P_W   = 30;
    localparam int DUTY_SHIFT = 22;
    localparam logic [DUTY_X_W-1:0] DUTY_BIAS  = DUTY_X_W'(12800);
    localparam logic [DUTY_P_W-1:0] DUTY_RECIP = DUTY_P_W'(41944);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_PERCENT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_PERCENT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BOOST_MS      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OFF_TEMP      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ON_TEMP       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_TEMP     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_RAMP_RATE     = 3'd6;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    // whole percent, saturated at 100, to 1/256 percent
    function automatic logic [LEVEL_W-1:0] pct_level(input logic [PCT_W-1:0] p);
        logic [PCT_W-1:0] c;
        c = (p > PCT_MAX) ? PCT_MAX : p;
        return {c, 8'b0};
    endfunction

endpackage

// File: sv/fan_speed_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller
// Hysteresis fan request, linear fan curve, start boost and rate-limited ramp.
// ----------------------------------------------------------------------------
// Each update transfer on the input stream carries a millisecond timestamp and
// a smoothed temperature (tdata) and a sensor fault flag (tuser); each one
// yields exactly one result transfer with the PWM duty, rounded percent, the
// applied and target levels (1/256 percent) and the boost and request flags.
// The block works on one update at a time: s_tready is high only while the
// sequencer is idle. After the idle state accepts it, an update goes through
// EVAL and EMIT on a fault or a released fan, EVAL, POST and EMIT while the
// boost starts or holds, and EVAL, POST, STEP, RAMP and EMIT for a ramp step
// toward a threshold target. A curve point between on_temp and full_temp also
// goes through CDIV and CWAIT for the serial divider, which yields one quotient
// bit per cycle over 29 bits. The ramp step itself is a constant reciprocal
// multiply, registered in STEP. A finished
// result sits in the output register until taken, and the next update is
// accepted meanwhile; a second result waits in the sequencer until the first
// one leaves. Configuration writes are always accepted (cfg_ready is tied
// high) and must only happen while idle; the register indexes follow the
// order min_percent, start_percent, boost_ms, off_temp, on_temp, full_temp,
// ramp_rate. Keep the thresholds consistent (off_temp <= on_temp < full_temp);
// other settings give defined but meaningless curves.
// ----------------------------------------------------------------------------
module fan_speed_controller
    import fsc_pkg::*;
#(
    parameter logic [DT_W-1:0] DEFAULT_STEP = DEFAULT_STEP_MS  // first time step, ms
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // update stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // now_ms[31:0], temperature[44:32], zero pad
    input  logic                  s_tuser,  // sensor_fault[0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // duty[7:0], fan_percent[14:8], fan_on[15],
                                            // fan_level[30:16], target_level[45:31],
                                            // boost_active[46], requested[47]
);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EVAL  = 4'd1;
    localparam logic [3:0] ST_CDIV  = 4'd2;
    localparam logic [3:0] ST_CWAIT = 4'd3;
    localparam logic [3:0] ST_POST  = 4'd4;
    localparam logic [3:0] ST_STEP  = 4'd5;
    localparam logic [3:0] ST_RAMP  = 4'd6;
    localparam logic [3:0] ST_EMIT  = 4'd7;

    localparam int PROD_W = DT_W + LEVEL_W;
    localparam int RD_W   = RAMP_W + DT_W;
    localparam int STEP_W = 19;

    // configuration registers
    logic        [PCT_W-1:0]   min_pct_reg, min_pct_next;
    logic        [PCT_W-1:0]   start_pct_reg, start_pct_next;
    logic        [BOOST_W-1:0] boost_ms_reg, boost_ms_next;
    logic signed [TEMP_W-1:0]  off_temp_reg, off_temp_next;
    logic signed [TEMP_W-1:0]  on_temp_reg, on_temp_next;
    logic signed [TEMP_W-1:0]  full_temp_reg, full_temp_next;
    logic        [RAMP_W-1:0]  ramp_reg, ramp_next;

    // control state
    logic [3:0]         state_reg, state_next;
    logic [TIME_W-1:0]  last_time_reg, last_time_next;
    logic               time_valid_reg, time_valid_next;
    logic               req_reg, req_next;
    logic               boost_reg, boost_next;
    logic [TIME_W-1:0]  deadline_reg, deadline_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               m_valid_reg, m_valid_next;

    // per-update working registers
    logic        [TIME_W-1:0]     now_reg, now_next;
    logic signed [TEMP_W-1:0]     temp_reg, temp_next;
    logic                         fault_reg, fault_next;
    logic        [DT_W-1:0]       dt_reg, dt_next;
    logic        [LEVEL_W-1:0]    target_reg, target_next;
    logic        [PROD_W-1:0]     prod_reg, prod_next;
    logic        [DIV_DEN_W-1:0]  den_reg, den_next;
    logic        [RD_W-1:0]       rd_reg, rd_next;
    logic        [STEP_W-1:0]     step_reg, step_next;
    logic        [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // combinational helpers
    logic [TIME_W-1:0]       now_in;
    logic [TIME_W-1:0]       gap;
    logic [DT_W-1:0]         dt_calc;
    logic [LEVEL_W-1:0]      lo_level;
    logic [LEVEL_W-1:0]      start_level;
    logic [TEMP_W:0]         t_minus_on;
    logic [TEMP_W:0]         full_minus_on;
    logic                    req_calc;
    logic [TIME_W-1:0]       boost_left;
    logic [STEP_Z_W-1:0]     step_z;
    logic [STEP_P_W-1:0]     step_p;
    logic [LEVEL_W-1:0]      up_gap;
    logic [LEVEL_W-1:0]      dn_gap;
    logic [LEVEL_W-1:0]      ramped;
    logic [LEVEL_W-1:0]      clamped;
    logic [DUTY_X_W-1:0]     duty_x;
    logic [DUTY_P_W-1:0]     duty_p;
    logic [7:0]              duty;
    logic [LEVEL_W:0]        pct_sum;
    logic [PCT_W-1:0]        fan_pct;
    logic                    emit_load;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    fsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // ------------------------------------------------------------------
    // Time step: wrapping difference, clamped to 1..5000 ms; the first
    // update after reset uses the default step.
    // ------------------------------------------------------------------
    assign now_in  = s_tdata[TIME_W-1:0];
    assign gap     = now_in - last_time_reg;
    assign dt_calc = !time_valid_reg              ? DEFAULT_STEP    :
                     (gap == '0)                  ? DT_W'(1)        :
                     (gap > TIME_W'(DT_MAX))      ? DT_MAX          :
                                                    gap[DT_W-1:0];

    assign lo_level    = pct_level(min_pct_reg);
    assign start_level = pct_level(start_pct_reg);

    // Curve terms; both are positive when on < t < full, the one case
    // that uses them.
    assign t_minus_on    = {temp_reg[TEMP_W-1], temp_reg}
                         - {on_temp_reg[TEMP_W-1], on_temp_reg};
    assign full_minus_on = {full_temp_reg[TEMP_W-1], full_temp_reg}
                         - {on_temp_reg[TEMP_W-1], on_temp_reg};

    // Hysteresis: request at or above on_temp, release below off_temp.
    assign req_calc = (temp_reg >= on_temp_reg) ? 1'b1 :
                      (temp_reg <  off_temp_reg) ? 1'b0 : req_reg;

    // Boost still running while now - deadline reads negative.
    assign boost_left = now_reg - deadline_reg;

    // ------------------------------------------------------------------
    // Ramp step = round(rate * 256 * dt / 1000). Taking out a factor of
    // four and a floored halving leaves floor((32 * rate * dt + 62) / 125),
    // done as a multiply by ceil(2^32 / 125) and a 32-bit shift; exact for
    // every rate * dt up to 255 * 5000.
    // ------------------------------------------------------------------
    assign step_z = {rd_reg, 5'b0} + STEP_BIAS;
    assign step_p = STEP_P_W'(step_z) * STEP_P_W'(STEP_RECIP);

    // ------------------------------------------------------------------
    // Ramp toward the target by at most one step, then clamp to
    // [min, full].
    // ------------------------------------------------------------------
    assign up_gap = target_reg - level_reg;
    assign dn_gap = level_reg - target_reg;

    always_comb
    begin
        ramped = level_reg;
        if (level_reg < target_reg)
        begin
            ramped = (STEP_W'(up_gap) > step_reg) ? level_reg + step_reg[LEVEL_W-1:0]
                                                  : target_reg;
        end
        else if (level_reg > target_reg)
        begin
            ramped = (STEP_W'(dn_gap) > step_reg) ? level_reg - step_reg[LEVEL_W-1:0]
                                                  : target_reg;
        end
        clamped = ramped;
        if (clamped < lo_level)
        begin
            clamped = lo_level;
        end
        if (clamped > FULL_LEVEL)
        begin
            clamped = FULL_LEVEL;
        end
    end

    // ------------------------------------------------------------------
    // Result fields from the applied level:
    // duty = round(level * 255 / 25600), fan_percent = round(level / 256).
    // ------------------------------------------------------------------
    assign duty_x  = {level_reg, 8'b0} - DUTY_X_W'(level_reg) + DUTY_BIAS;
    assign duty_p  = DUTY_P_W'(duty_x[DUTY_X_W-1:8]) * DUTY_RECIP;
    assign duty    = (level_reg == '0) ? 8'd0 : duty_p[DUTY_SHIFT +: 8];
    assign pct_sum = (LEVEL_W + 1)'(level_reg) + (LEVEL_W + 1)'(128);
    assign fan_pct = pct_sum[LEVEL_W-1:8];

    // Load the output register once the previous result is gone or leaving.
    assign emit_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    // ------------------------------------------------------------------
    // Divider request: curve slope in ST_CDIV.
    // ------------------------------------------------------------------
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = DIV_NUM_W'(prod_reg) + DIV_NUM_W'(den_reg[DIV_DEN_W-1:1]);
        div_req.den   = den_reg;
        case (state_reg)
            ST_CDIV:
            begin
                div_req.start = 1'b1;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped.
    // ------------------------------------------------------------------
    always_comb
    begin
        min_pct_next   = min_pct_reg;
        start_pct_next = start_pct_reg;
        boost_ms_next  = boost_ms_reg;
        off_temp_next  = off_temp_reg;
        on_temp_next   = on_temp_reg;
        full_temp_next = full_temp_reg;
        ramp_next      = ramp_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_MIN_PERCENT:   min_pct_next   = cfg_data[PCT_W-1:0];
                REG_START_PERCENT: start_pct_next = cfg_data[PCT_W-1:0];
                REG_BOOST_MS:      boost_ms_next  = cfg_data[BOOST_W-1:0];
                REG_OFF_TEMP:      off_temp_next  = $signed(cfg_data[TEMP_W-1:0]);
                REG_ON_TEMP:       on_temp_next   = $signed(cfg_data[TEMP_W-1:0]);
                REG_FULL_TEMP:     full_temp_next = $signed(cfg_data[TEMP_W-1:0]);
                REG_RAMP_RATE:     ramp_next      = cfg_data[RAMP_W-1:0];
                default:
                begin
                    ramp_next = ramp_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        last_time_next  = last_time_reg;
        time_valid_next = time_valid_reg;
        req_next        = req_reg;
        boost_next      = boost_reg;
        deadline_next   = deadline_reg;
        level_next      = level_reg;
        now_next        = now_reg;
        temp_next       = temp_reg;
        fault_next      = fault_reg;
        dt_next         = dt_reg;
        target_next     = target_reg;
        prod_next       = prod_reg;
        den_next        = den_reg;
        rd_next         = rd_reg;
        step_next       = step_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                // take the update and advance the time base
                if (s_tvalid)
                begin
                    now_next        = now_in;
                    temp_next       = $signed(s_tdata[TIME_W +: TEMP_W]);
                    fault_next      = s_tuser;
                    dt_next         = dt_calc;
                    last_time_next  = now_in;
                    time_valid_next = 1'b1;
                    state_next      = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (fault_reg)
                begin
                    // sensor fault: full speed, boost cancelled
                    req_next    = 1'b1;
                    boost_next  = 1'b0;
                    level_next  = FULL_LEVEL;
                    target_next = FULL_LEVEL;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    req_next = req_calc;
                    if (!req_calc)
                    begin
                        boost_next  = 1'b0;
                        level_next  = '0;
                        target_next = '0;
                        state_next  = ST_EMIT;
                    end
                    else if (temp_reg >= full_temp_reg)
                    begin
                        target_next = FULL_LEVEL;
                        state_next  = ST_POST;
                    end
                    else if (temp_reg <= on_temp_reg)
                    begin
                        target_next = lo_level;
                        state_next  = ST_POST;
                    end
                    else
                    begin
                        // interpolate: (t - on) * (full - lo) / (full - on)
                        prod_next  = PROD_W'(t_minus_on[TEMP_W-1:0])
                                   * PROD_W'(FULL_LEVEL - lo_level);
                        den_next   = full_minus_on[DIV_DEN_W-1:0];
                        state_next = ST_CDIV;
                    end
                end
            end
            ST_CDIV:
            begin
                state_next = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                if (div_rsp.done)
                begin
                    target_next = lo_level + div_rsp.quot[LEVEL_W-1:0];
                    state_next  = ST_POST;
                end
            end
            ST_POST:
            begin
                if ((level_reg == '0) && !boost_reg)
                begin
                    // start from standstill: arm the boost
                    boost_next    = 1'b1;
                    deadline_next = now_reg + TIME_W'(boost_ms_reg);
                    level_next    = start_level;
                    state_next    = ST_EMIT;
                end
                else if (boost_reg && boost_left[TIME_W-1])
                begin
                    // hold the boost level until the deadline
                    level_next = start_level;
                    state_next = ST_EMIT;
                end
                else
                begin
                    boost_next = 1'b0;
                    rd_next    = RD_W'(ramp_reg) * RD_W'(dt_reg);
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                step_next  = step_p[STEP_SHIFT +: STEP_W];
                state_next = ST_RAMP;
            end
            ST_RAMP:
            begin
                level_next = clamped;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {req_reg, boost_reg, target_reg, level_reg,
                                    (duty != 8'd0), fan_pct, duty};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pct_reg    <= PCT_W'(20);
            start_pct_reg  <= PCT_W'(50);
            boost_ms_reg   <= BOOST_W'(1000);
            off_temp_reg   <= TEMP_W'(560);
            on_temp_reg    <= TEMP_W'(640);
            full_temp_reg  <= TEMP_W'(960);
            ramp_reg       <= RAMP_W'(20);
            state_reg      <= ST_IDLE;
            last_time_reg  <= '0;
            time_valid_reg <= 1'b0;
            req_reg        <= 1'b0;
            boost_reg      <= 1'b0;
            deadline_reg   <= '0;
            level_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            min_pct_reg    <= min_pct_next;
            start_pct_reg  <= start_pct_next;
            boost_ms_reg   <= boost_ms_next;
            off_temp_reg   <= off_temp_next;
            on_temp_reg    <= on_temp_next;
            full_temp_reg  <= full_temp_next;
            ramp_reg       <= ramp_next;
            state_reg      <= state_next;
            last_time_reg  <= last_time_next;
            time_valid_reg <= time_valid_next;
            req_reg        <= req_next;
            boost_reg      <= boost_next;
            deadline_reg   <= deadline_next;
            level_reg      <= level_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        temp_reg   <= temp_next;
        fault_reg  <= fault_next;
        dt_reg     <= dt_next;
        target_reg <= target_next;
        prod_reg   <= prod_next;
        den_reg    <= den_next;
        rd_reg     <= rd_next;
        step_reg   <= step_next;
        m_data_reg <= m_data_next;
    end

endmodule

// File: sv/fsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsc_div
    import fsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = CNT_W'(DIV_NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next numerator bit, subtract when it fits
            rem_next = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

// File: sv/fsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller port checker
// Watches the stream ports of the top level and checks result consistency.
// ----------------------------------------------------------------------------
`include "fan_speed_controller_macros.svh"

module fsc_checker
    import fsc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // hold a stalled result
    `FSC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // fan_on flags a nonzero duty
    `FSC_ASSERT_NOW(a_fan_on, clk, rst_n, m_tvalid, m_tdata[15] == (m_tdata[7:0] != 8'd0))

    // a released fan shows zero level, zero target and no boost
    `FSC_ASSERT_NOW(a_released, clk, rst_n, m_tvalid && !m_tdata[47], (m_tdata[30:16] == 15'd0) && (m_tdata[45:31] == 15'd0) && !m_tdata[46])

    // one update at a time: ready drops after an input transfer
    `FSC_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind fan_speed_controller fsc_checker u_fsc_checker (.*);

// File: dv/tb_fan_speed_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller testbench
// Streams timestamped temperature updates through the controller and checks
// every result against a cycle-free model of the fan curve, hysteresis, start
// boost and ramp, across several register settings with random idling on
// both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_fan_speed_controller;

    import fsc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 180;
    localparam int PHASES = 8;

    // one update as sent on the input stream
    typedef struct packed {
        logic        sensor_fault;
        logic [12:0] temperature;
        logic [31:0] now_ms;
    } fan_update_t;

    // one result, laid out exactly as m_tdata (lowest field last)
    typedef struct packed {
        logic        requested;
        logic        boost_active;
        logic [14:0] target_level;
        logic [14:0] fan_level;
        logic        fan_on;
        logic [6:0]  fan_percent;
        logic [7:0]  duty;
    } fan_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;  // now_ms[31:0], temperature[44:32], zero pad
    logic                  s_tuser = 1'b0; // sensor_fault[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;  // duty, fan_percent, fan_on, fan_level,
                                     // target_level, boost_active, requested

    fan_speed_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Controller model: register copy and running state
    // ------------------------------------------------------------------------
    logic [6:0]  cfg_min_pct   = 7'd20;
    logic [6:0]  cfg_start_pct = 7'd50;
    logic [15:0] cfg_boost_ms  = 16'd1000;
    int          cfg_off       = 560;
    int          cfg_on        = 640;
    int          cfg_full      = 960;
    logic [7:0]  cfg_ramp      = 8'd20;

    logic [31:0] last_ms     = '0;
    bit          clock_valid = 1'b0;
    bit          fan_wanted  = 1'b0;
    bit          boost_on    = 1'b0;
    logic [31:0] boost_end   = '0;
    int          level       = 0;

    fan_update_t update_q[$];
    fan_result_t pending_fan_results[$];
    fan_update_t offered;

    int send_idle_max = 3;
    int recv_idle_max = 3;
    int send_wait = 0;
    int recv_wait = 0;
    int mismatch_count = 0;
    int result_count = 0;
    bit pressure_armed = 1'b0;
    logic hold_off = 1'b0;

    // stimulus walk state
    logic [31:0] now_clock;
    int walk_temp = 700;

    // whole percent, saturated at 100, to 1/256 percent
    function automatic int percent_to_level(input logic [6:0] p);
        return ((p > 7'd100) ? 100 : int'(p)) * 256;
    endfunction

    // Advance the model by one update and return the result it must produce.
    function automatic fan_result_t compute_fan_response(input fan_update_t u);
        logic [31:0] dt;
        logic [31:0] since_deadline;
        int temp_now;
        int floor_level;
        int goal;
        int step;
        int num;
        int den;
        fan_result_t r;

        temp_now = int'($signed(u.temperature));
        floor_level = percent_to_level(cfg_min_pct);

        // clamp the time step; the very first update uses the default step
        dt = clock_valid ? u.now_ms - last_ms : 32'(DEFAULT_STEP_MS);
        if (dt == 32'd0)
            dt = 32'd1;
        else if (dt > 32'd5000)
            dt = 32'd5000;
        last_ms = u.now_ms;
        clock_valid = 1'b1;

        if (u.sensor_fault)
        begin
            fan_wanted = 1'b1;
            boost_on = 1'b0;
            level = int'(FULL_LEVEL);
            goal = int'(FULL_LEVEL);
        end
        else
        begin
            if (temp_now >= cfg_on)
                fan_wanted = 1'b1;
            else if (temp_now < cfg_off)
                fan_wanted = 1'b0;

            if (!fan_wanted)
            begin
                boost_on = 1'b0;
                level = 0;
                goal = 0;
            end
            else
            begin
                // full threshold wins over the on threshold
                if (temp_now >= cfg_full)
                    goal = int'(FULL_LEVEL);
                else if (temp_now <= cfg_on)
                    goal = floor_level;
                else
                begin
                    num = (temp_now - cfg_on) * (int'(FULL_LEVEL) - floor_level);
                    den = cfg_full - cfg_on;
                    goal = floor_level + (num + den / 2) / den;
                end

                since_deadline = u.now_ms - boost_end;
                if (level == 0 && !boost_on)
                begin
                    // start from standstill: arm the boost
                    boost_on = 1'b1;
                    boost_end = u.now_ms + 32'(cfg_boost_ms);
                    level = percent_to_level(cfg_start_pct);
                end
                else if (boost_on && since_deadline[31])
                    level = percent_to_level(cfg_start_pct);
                else
                begin
                    boost_on = 1'b0;
                    step = (int'(cfg_ramp) * 256 * int'(dt) + 500) / 1000;
                    if (level < goal)
                        level = (goal - level > step) ? level + step : goal;
                    else if (level > goal)
                        level = (level - goal > step) ? level - step : goal;
                    if (level < floor_level)
                        level = floor_level;
                    if (level > int'(FULL_LEVEL))
                        level = int'(FULL_LEVEL);
                end
            end
        end

        r.fan_level    = 15'(level);
        r.target_level = 15'(goal);
        r.duty         = (level == 0) ? 8'd0 : 8'((level * 255 + 12800) / 25600);
        r.fan_percent  = 7'((level + 128) / 256);
        r.fan_on       = (r.duty != 8'd0);
        r.boost_active = boost_on;
        r.requested    = fan_wanted;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Update driver: present queued updates, predict on each transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_fan_results.push_back(compute_fan_response(offered));
            // the slot is free when nothing is offered or the offer just went
            if (!s_tvalid || s_tready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (update_q.size() > 0)
                begin
                    offered = update_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(IN_DATA_W - 45){1'b0}}, offered.temperature,
                                offered.now_ms};
                    s_tuser <= offered.sensor_fault;
                    send_wait = $urandom_range(0, send_idle_max);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each transfer against the oldest prediction,
    // then decide whether to stall the next one
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        fan_result_t got;
        fan_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                result_count++;
                if (pending_fan_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d arrived with nothing predicted", result_count);
                end
                else
                begin
                    want = pending_fan_results.pop_front();
                    if (got.duty != want.duty || got.fan_percent != want.fan_percent ||
                        got.fan_on != want.fan_on || got.fan_level != want.fan_level ||
                        got.target_level != want.target_level ||
                        got.boost_active != want.boost_active ||
                        got.requested != want.requested)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("result %0d expected duty %0d pct %0d on %0b lvl %0d",
                                     result_count, want.duty, want.fan_percent,
                                     want.fan_on, want.fan_level);
                            $display("    tgt %0d boost %0b req %0b", want.target_level,
                                     want.boost_active, want.requested);
                            $display("  got duty %0d pct %0d on %0b lvl %0d", got.duty,
                                     got.fan_percent, got.fan_on, got.fan_level);
                            $display("    tgt %0d boost %0b req %0b", got.target_level,
                                     got.boost_active, got.requested);
                        end
                    end
                end
                recv_wait = $urandom_range(0, recv_idle_max);
            end
            // count a stall down only while a result is waiting, so gaps land after valid rises
            if (hold_off)
                m_tready <= 1'b0;
            else if (recv_wait > 0)
            begin
                m_tready <= 1'b0;
                if (m_tvalid)
                    recv_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Long output hold-off: the sender keeps offering, so the block must back up.
    initial
    begin
        wait (pressure_armed);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Hard stop for a hung run.
    initial
    begin
        #6_000_000;
        $display("tb_fan_speed_controller: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic bit stream_busy();
        return update_q.size() != 0 || s_tvalid || pending_fan_results.size() != 0;
    endfunction

    task automatic wait_for_idle();
        while (stream_busy())
            @(posedge clk);
    endtask

    // Write one register and mirror it into the model on the transfer.
    task automatic write_setting(input logic [CFG_ADDR_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_PERCENT:   cfg_min_pct = 7'(value);
            REG_START_PERCENT: cfg_start_pct = 7'(value);
            REG_BOOST_MS:      cfg_boost_ms = 16'(value);
            REG_OFF_TEMP:      cfg_off = int'($signed(13'(value)));
            REG_ON_TEMP:       cfg_on = int'($signed(13'(value)));
            REG_FULL_TEMP:     cfg_full = int'($signed(13'(value)));
            REG_RAMP_RATE:     cfg_ramp = 8'(value);
            default:           ;
        endcase
    endtask

    task automatic program_settings(input int p_min, input int p_start, input int p_boost,
                                    input int p_off, input int p_on, input int p_full,
                                    input int p_ramp);
        write_setting(REG_MIN_PERCENT, p_min);
        write_setting(REG_START_PERCENT, p_start);
        write_setting(REG_BOOST_MS, p_boost);
        write_setting(REG_OFF_TEMP, p_off);
        write_setting(REG_ON_TEMP, p_on);
        write_setting(REG_FULL_TEMP, p_full);
        write_setting(REG_RAMP_RATE, p_ramp);
    endtask

    function automatic void put_update(input logic [31:0] t_ms, input int temp,
                                       input bit fault);
        fan_update_t u;
        u.now_ms = t_ms;
        u.temperature = 13'(temp);
        u.sensor_fault = fault;
        update_q.push_back(u);
    endfunction

    // Random updates: time mostly advances in small steps with stalls, long
    // gaps and jumps; temperature mostly walks around the thresholds.
    task automatic queue_random_updates(input int count);
        int pick;
        int lo_w;
        int hi_w;
        int temp;
        lo_w = ((cfg_off < cfg_on) ? cfg_off : cfg_on) - 200;
        hi_w = ((cfg_full > cfg_on) ? cfg_full : cfg_on) + 200;
        if (lo_w < -4096)
            lo_w = -4096;
        if (hi_w > 4095)
            hi_w = 4095;
        if (walk_temp < lo_w || walk_temp > hi_w)
            walk_temp = lo_w;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                now_clock = $urandom();
            else if (pick >= 6 && pick < 12)
                now_clock += $urandom_range(5000, 70000);
            else if (pick >= 12)
                now_clock += $urandom_range(1, 1200);

            pick = $urandom_range(0, 99);
            if (pick < 12)
                temp = int'($signed(13'($urandom())));
            else if (pick < 22)
            begin
                case ($urandom_range(0, 5))
                    0: temp = cfg_off - 1;
                    1: temp = cfg_off;
                    2: temp = cfg_on - 1;
                    3: temp = cfg_on;
                    4: temp = cfg_full - 1;
                    default: temp = cfg_full;
                endcase
            end
            else
            begin
                if (pick < 30)
                    walk_temp = lo_w + int'($urandom_range(0, hi_w - lo_w));
                else
                    walk_temp += int'($urandom_range(0, 80)) - 40;
                if (walk_temp < lo_w)
                    walk_temp = lo_w;
                if (walk_temp > hi_w)
                    walk_temp = hi_w;
                temp = walk_temp;
            end
            put_update(now_clock, temp, pick < 5);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int p_off;
        int p_on;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed updates at the reset settings (off 560, on 640, full 960,
        // boost 1000 ms at 50 %, min 20 %, ramp 20 %/s).
        put_update(32'hFFFF_FE00, 800, 1'b0);   // first update: default step, boost starts
        put_update(32'hFFFF_FF00, 800, 1'b0);   // boost holds
        put_update(32'h0000_0100, 800, 1'b0);   // time wraps, boost deadline not yet reached
        put_update(32'h0000_0300, 800, 1'b0);   // boost over, ramp toward the curve
        put_update(32'h0000_0300, 800, 1'b0);   // same time: step clamped up to 1 ms
        put_update(32'h0000_0200, 2400, 1'b0);  // time goes back: step clamped to 5 s
        put_update(32'h0000_0400, 4095, 1'b0);  // hottest reading
        put_update(32'h0000_0600, -4096, 1'b1); // sensor fault with coldest reading
        put_update(32'h0000_0800, 600, 1'b0);   // inside the hysteresis band, still on
        put_update(32'h0000_0A00, 560, 1'b0);   // exactly at off: still on
        put_update(32'h0000_0C00, 559, 1'b0);   // just below off: released
        put_update(32'h0000_0E00, 600, 1'b0);   // band while released: stays off
        put_update(32'h0000_1000, 639, 1'b0);
        put_update(32'h0000_1200, 640, 1'b0);   // exactly at on: request, target at min
        put_update(32'h0000_1300, 959, 1'b0);   // near full during boost
        put_update(32'h0000_1400, 4095, 1'b1);  // fault cancels the boost
        put_update(32'h0000_1600, 960, 1'b0);   // exactly at full
        put_update(32'h0000_1800, -800, 1'b0);  // released from full
        put_update(32'hFFFF_FFFF, 961, 1'b0);   // restart with deadline past the wrap
        put_update(32'h7FFF_FFFF, 700, 1'b0);   // huge jump ends the boost
        put_update(32'h0000_0000, 0, 1'b0);
        put_update(32'h8000_0000, -1, 1'b0);
        now_clock = 32'h8000_0000;
        wait_for_idle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            send_idle_max = 3;
            recv_idle_max = 3;
            case (phase)
                0: ;  // stay at the reset settings
                1: program_settings(0, 100, 0, -800, -800, 2400, 255);
                2: program_settings(100, 0, 60000, 2400, 2400, 2400, 1);
                3: program_settings(127, 127, 65535, 4095, -4096, 4095, 0);
                7: program_settings($urandom_range(0, 127), $urandom_range(0, 127),
                                    $urandom_range(0, 65535),
                                    int'($signed(13'($urandom()))),
                                    int'($signed(13'($urandom()))),
                                    int'($signed(13'($urandom()))),
                                    $urandom_range(0, 255));
                default:
                begin
                    p_off = int'($urandom_range(0, 2800)) - 800;
                    p_on = p_off + int'($urandom_range(0, 200));
                    program_settings($urandom_range(0, 100), $urandom_range(0, 100),
                                     $urandom_range(0, 3000), p_off, p_on,
                                     p_on + int'($urandom_range(1, 2400 - p_on)),
                                     $urandom_range(1, 255));
                end
            endcase
            if (phase == 5)
            begin
                // back-to-back offers against a long output stall
                send_idle_max = 0;
                pressure_armed = 1'b1;
            end
            if (phase == 6)
            begin
                send_idle_max = 0;
                recv_idle_max = 0;
            end
            queue_random_updates(RANDOM_PER_PHASE);
            wait_for_idle();
        end

        // drain anything still outstanding, bounded, then let the block settle
        for (int n = 0; n < 5000 && stream_busy(); n++)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatch_count == 0 && pending_fan_results.size() == 0)
            $display("tb_fan_speed_controller: done, clean");
        else
            $display("tb_fan_speed_controller: done, errors");
        $finish;
    end

endmodule
